// File: rtl/prc2d_pkg.sv
// Shared types, constants and helper functions for the 2D pose constraint block.
// Used by the front stage, the CORDIC stages, the back end and the top level.
package prc2d_pkg;

  // Internal widths: CORDIC datapath, position difference, angle residual.
  localparam int CW = 34;
  localparam int DW = 33;
  localparam int AW = 28;

  // Q2.30 angle and gain constants.
  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_OBS_DX   = 3'd0,
    REG_OBS_DY   = 3'd1,
    REG_OBS_TURN = 3'd2,
    REG_TW       = 3'd3,
    REG_RW       = 3'd4
  } cfg_reg_t;

  // Item state carried through the CORDIC chain.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [AW-1:0] ang;
    logic                 flip;
  } cord_t;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] a;
    case (i)
      0: a = 34'sd843314857;
      1: a = 34'sd497837829;
      2: a = 34'sd263043837;
      3: a = 34'sd133525159;
      4: a = 34'sd67021687;
      5: a = 34'sd33543516;
      6: a = 34'sd16775851;
      7: a = 34'sd8388437;
      8: a = 34'sd4194283;
      9: a = 34'sd2097149;
      10: a = 34'sd1048576;
      11: a = 34'sd524288;
      12: a = 34'sd262144;
      13: a = 34'sd131072;
      14: a = 34'sd65536;
      15: a = 34'sd32768;
      16: a = 34'sd16384;
      17: a = 34'sd8192;
      18: a = 34'sd4096;
      19: a = 34'sd2048;
      20: a = 34'sd1024;
      21: a = 34'sd512;
      22: a = 34'sd256;
      23: a = 34'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/prc2d_ifs.sv
// Handshake interfaces for the pose pair input, the result output and the register writes.
// Depends on nothing but the signal widths of the block's fields.
interface prc2d_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [18:0] start_heading;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [18:0] end_heading;

  modport source (output valid, start_x, start_y, start_heading, end_x, end_y, end_heading,
                  input ready);
  modport sink (input valid, start_x, start_y, start_heading, end_x, end_y, end_heading,
                output ready);
endinterface

interface prc2d_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] residual_x;
  logic signed [31:0] residual_y;
  logic signed [31:0] residual_angle;
  logic signed [31:0] weighted_cosine;
  logic signed [31:0] weighted_sine;
  logic signed [31:0] jac_x_by_heading;
  logic signed [31:0] jac_y_by_heading;

  modport source (output valid, residual_x, residual_y, residual_angle, weighted_cosine,
                  weighted_sine, jac_x_by_heading, jac_y_by_heading, input ready);
  modport sink (input valid, residual_x, residual_y, residual_angle, weighted_cosine,
                weighted_sine, jac_x_by_heading, jac_y_by_heading, output ready);
endinterface

interface prc2d_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/prc2d_front.sv
// Front stage: position difference, heading wrap and quadrant fold, angle residual wrap.
// Depends on prc2d_pkg.
module prc2d_front
  import prc2d_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [18:0] start_heading,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [18:0] end_heading,
  input  logic signed [18:0] obs_turn,
  output logic               valid_r,
  output cord_t              st_r
);

  localparam int ZW = (49 - FRAC_BITS > CW) ? 49 - FRAC_BITS : CW;
  localparam int ZSTEPS = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int ASTEPS = (FRAC_BITS < 18) ? 18 - FRAC_BITS : 0;
  localparam longint PI_F = (64'sd3373259426 + (64'sd1 <<< (29 - FRAC_BITS)))
                            >>> (30 - FRAC_BITS);
  localparam logic signed [ZW-1:0] PI_Z = ZW'(PI_Q30);
  localparam logic signed [ZW-1:0] TWO_PI_Z = PI_Z + PI_Z;
  localparam logic signed [AW-1:0] PI_A = AW'(PI_F);
  localparam logic signed [AW-1:0] TWO_PI_A = PI_A + PI_A;

  logic signed [ZW-1:0] zt;
  logic signed [ZW-1:0] zc;
  logic signed [AW-1:0] at;
  logic signed [AW-1:0] ac;
  logic                 flip;
  cord_t                st_nxt;

  // Heading into Q2.30, wrapped into [-pi, pi] and folded into [-pi/2, pi/2].
  always_comb begin
    zt = ZW'(start_heading) <<< (30 - FRAC_BITS);
    for (int k = ZSTEPS - 1; k >= 0; k--) begin
      zc = TWO_PI_Z <<< k;
      if (zt - zc > PI_Z) begin
        zt = zt - zc;
      end else if (zt + zc < -PI_Z) begin
        zt = zt + zc;
      end
    end
    if (zt > PI_Z) begin
      zt = zt - TWO_PI_Z;
    end else if (zt < -PI_Z) begin
      zt = zt + TWO_PI_Z;
    end
    flip = 1'b0;
    if (zt > ZW'(HALF_PI_Q30)) begin
      zt = zt - PI_Z;
      flip = 1'b1;
    end else if (zt < -ZW'(HALF_PI_Q30)) begin
      zt = zt + PI_Z;
      flip = 1'b1;
    end
  end

  // Angle residual before weighting, wrapped into [-pi, pi].
  always_comb begin
    at = AW'(obs_turn) - (AW'(end_heading) - AW'(start_heading));
    for (int k = ASTEPS - 1; k >= 0; k--) begin
      ac = TWO_PI_A <<< k;
      if (at - ac > PI_A) begin
        at = at - ac;
      end else if (at + ac < -PI_A) begin
        at = at + ac;
      end
    end
    if (at > PI_A) begin
      at = at - TWO_PI_A;
    end else if (at < -PI_A) begin
      at = at + TWO_PI_A;
    end
  end

  always_comb begin
    st_nxt.x    = GAIN_Q30;
    st_nxt.y    = '0;
    st_nxt.z    = CW'(zt);
    st_nxt.dx   = DW'(end_x) - DW'(start_x);
    st_nxt.dy   = DW'(end_y) - DW'(start_y);
    st_nxt.ang  = at;
    st_nxt.flip = flip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: rtl/prc2d_cordic_stage.sv
// One rotation-mode CORDIC iteration with its pipeline register.
// Depends on prc2d_pkg for the item struct and the arctangent table.
module prc2d_cordic_stage
  import prc2d_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  valid_in,
  input  cord_t st_in,
  output logic  valid_r,
  output cord_t st_r
);

  cord_t st_nxt;

  // Rotate toward zero residual angle.
  always_comb begin
    st_nxt = st_in;
    if (st_in.z >= 0) begin
      st_nxt.x = st_in.x - (st_in.y >>> IDX);
      st_nxt.y = st_in.y + (st_in.x >>> IDX);
      st_nxt.z = st_in.z - atan_q30(IDX);
    end else begin
      st_nxt.x = st_in.x + (st_in.y >>> IDX);
      st_nxt.y = st_in.y - (st_in.x >>> IDX);
      st_nxt.z = st_in.z + atan_q30(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: rtl/prc2d_back.sv
// Back end: sine/cosine cleanup, rotation, weighting, Jacobian terms and output register.
// Four register stages; depends on prc2d_pkg.
module prc2d_back
  import prc2d_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_in,
  input  cord_t              st_in,
  input  logic signed [31:0] obs_dx,
  input  logic signed [31:0] obs_dy,
  input  logic [23:0]        tw,
  input  logic [23:0]        rw,
  output logic               valid_r,
  output logic signed [31:0] res_x_r,
  output logic signed [31:0] res_y_r,
  output logic signed [31:0] res_ang_r,
  output logic signed [31:0] wc_out_r,
  output logic signed [31:0] ws_out_r,
  output logic signed [31:0] jx_r,
  output logic signed [31:0] jy_r
);

  localparam logic signed [63:0] HALF_F = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] HALF_30 = 66'sd1 <<< 29;

  logic [2:0] vld_r;

  // Stage 1 signals.
  logic signed [CW-1:0] xf, yf;
  logic signed [31:0]   c, s;
  logic signed [24:0]   tw_s, rw_s;
  logic signed [64:0]   cdx_r, sdy_r, cdy_r, sdx_r;
  logic signed [56:0]   twc_r, tws_r;
  logic signed [52:0]   rang_r;
  logic signed [DW-1:0] dx1_r, dy1_r;

  // Stage 2 signals.
  logic signed [65:0]   sx_sum, sy_sum;
  logic signed [35:0]   rx_r, ry_r;
  logic signed [26:0]   wc_r, ws_r;
  logic signed [31:0]   ra2_r;
  logic signed [DW-1:0] dx2_r, dy2_r;
  logic signed [56:0]   twc_rnd, tws_rnd;
  logic signed [63:0]   rang_rnd;

  // Stage 3 signals.
  logic signed [37:0]   ex, ey;
  logic signed [62:0]   pex_r, pey_r;
  logic signed [59:0]   wsdx_r, wcdy_r, wcdx_r, wsdy_r;
  logic signed [26:0]   wc3_r, ws3_r;
  logic signed [31:0]   ra3_r;

  // Stage 4 signals.
  logic signed [63:0]   jx_sum, jy_sum;

  assign tw_s = {1'b0, tw};
  assign rw_s = {1'b0, rw};

  // Undo the quadrant fold and clamp sine and cosine to the unit range.
  always_comb begin
    xf = st_in.flip ? -st_in.x : st_in.x;
    yf = st_in.flip ? -st_in.y : st_in.y;
    if (xf > ONE_Q30) begin
      c = 32'(ONE_Q30);
    end else if (xf < -ONE_Q30) begin
      c = 32'(-ONE_Q30);
    end else begin
      c = xf[31:0];
    end
    if (yf > ONE_Q30) begin
      s = 32'(ONE_Q30);
    end else if (yf < -ONE_Q30) begin
      s = 32'(-ONE_Q30);
    end else begin
      s = yf[31:0];
    end
  end

  // Stage 1: rotation and weight products.
  always_ff @(posedge clk) begin
    if (en) begin
      cdx_r  <= 65'(c) * 65'(st_in.dx);
      sdy_r  <= 65'(s) * 65'(st_in.dy);
      cdy_r  <= 65'(c) * 65'(st_in.dy);
      sdx_r  <= 65'(s) * 65'(st_in.dx);
      twc_r  <= 57'(tw_s) * 57'(c);
      tws_r  <= 57'(tw_s) * 57'(s);
      rang_r <= 53'(rw_s) * 53'(st_in.ang);
      dx1_r  <= st_in.dx;
      dy1_r  <= st_in.dy;
    end
  end

  // Stage 2: rounding of the rotated difference and the weighted sine and cosine.
  always_comb begin
    sx_sum   = (66'(cdx_r) + 66'(sdy_r) + HALF_30) >>> 30;
    sy_sum   = (66'(cdy_r) - 66'(sdx_r) + HALF_30) >>> 30;
    twc_rnd  = (twc_r + (57'sd1 <<< 29)) >>> 30;
    tws_rnd  = (tws_r + (57'sd1 <<< 29)) >>> 30;
    rang_rnd = (64'(rang_r) + HALF_F) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r  <= sx_sum[35:0];
      ry_r  <= sy_sum[35:0];
      wc_r  <= twc_rnd[26:0];
      ws_r  <= tws_rnd[26:0];
      ra2_r <= sat32(rang_rnd);
      dx2_r <= dx1_r;
      dy2_r <= dy1_r;
    end
  end

  // Stage 3: residual weighting and Jacobian products.
  always_comb begin
    ex = 38'(obs_dx) - 38'(rx_r);
    ey = 38'(obs_dy) - 38'(ry_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pex_r  <= 63'(tw_s) * 63'(ex);
      pey_r  <= 63'(tw_s) * 63'(ey);
      wsdx_r <= 60'(ws_r) * 60'(dx2_r);
      wcdy_r <= 60'(wc_r) * 60'(dy2_r);
      wcdx_r <= 60'(wc_r) * 60'(dx2_r);
      wsdy_r <= 60'(ws_r) * 60'(dy2_r);
      wc3_r  <= wc_r;
      ws3_r  <= ws_r;
      ra3_r  <= ra2_r;
    end
  end

  // Stage 4: final rounding and saturation into the output register.
  always_comb begin
    jx_sum = 64'(wsdx_r) - 64'(wcdy_r);
    jy_sum = 64'(wcdx_r) + 64'(wsdy_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_x_r   <= sat32((64'(pex_r) + HALF_F) >>> FRAC_BITS);
      res_y_r   <= sat32((64'(pey_r) + HALF_F) >>> FRAC_BITS);
      res_ang_r <= ra3_r;
      wc_out_r  <= sat32(64'(wc3_r));
      ws_out_r  <= sat32(64'(ws3_r));
      jx_r      <= sat32((jx_sum + HALF_F) >>> FRAC_BITS);
      jy_r      <= sat32((jy_sum + HALF_F) >>> FRAC_BITS);
    end
  end

  // Valid bits follow the data through the four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      valid_r <= 1'b0;
    end else if (en) begin
      vld_r   <= {vld_r[1:0], valid_in};
      valid_r <= vld_r[2];
    end
  end

endmodule

// File: rtl/pose_constraint_residual_jacobian_2d.sv
// Each transaction on in_ch carries a start pose and an end pose; one transaction on out_ch
// returns the three weighted residuals and the four distinct Jacobian values. The pipeline
// accepts one pose pair per cycle unless out_ch stalls. It has one front stage, one stage
// per CORDIC iteration and four multiply/round stages ending in the output register. When a
// result waits on out_ch the whole pipeline holds, so in_ch.ready follows out_ch.ready.
// Write registers through cfg_ch only while the block is idle; the block does not check.
module pose_constraint_residual_jacobian_2d
  import prc2d_pkg::*;
#(
  parameter int CORDIC_STAGES = 18,
  parameter int FRAC_BITS = 16
) (
  input logic         clk,
  input logic         rst_n,
  prc2d_in_if.sink    in_ch,
  prc2d_out_if.source out_ch,
  prc2d_cfg_if.sink   cfg_ch
);

  logic signed [31:0] obs_dx_r;
  logic signed [31:0] obs_dy_r;
  logic signed [18:0] obs_turn_r;
  logic [23:0]        tw_r;
  logic [23:0]        rw_r;

  logic               adv;
  logic               stage_vld [CORDIC_STAGES+1];
  cord_t              stage_st  [CORDIC_STAGES+1];

  // The pipeline moves whenever the output register is free or being emptied.
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign cfg_ch.ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obs_dx_r   <= '0;
      obs_dy_r   <= '0;
      obs_turn_r <= '0;
      tw_r       <= 24'(64'd1 << FRAC_BITS);
      rw_r       <= 24'(64'd1 << FRAC_BITS);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_OBS_DX:   obs_dx_r   <= cfg_ch.data;
        REG_OBS_DY:   obs_dy_r   <= cfg_ch.data;
        REG_OBS_TURN: obs_turn_r <= cfg_ch.data[18:0];
        REG_TW:       tw_r       <= cfg_ch.data[23:0];
        REG_RW:       rw_r       <= cfg_ch.data[23:0];
        default: ;
      endcase
    end
  end

  prc2d_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv),
    .in_valid      (in_ch.valid),
    .start_x       (in_ch.start_x),
    .start_y       (in_ch.start_y),
    .start_heading (in_ch.start_heading),
    .end_x         (in_ch.end_x),
    .end_y         (in_ch.end_y),
    .end_heading   (in_ch.end_heading),
    .obs_turn      (obs_turn_r),
    .valid_r       (stage_vld[0]),
    .st_r          (stage_st[0])
  );

  // CORDIC iterations, one register stage each.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    prc2d_cordic_stage #(
      .IDX(i)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .valid_in (stage_vld[i]),
      .st_in    (stage_st[i]),
      .valid_r  (stage_vld[i+1]),
      .st_r     (stage_st[i+1])
    );
  end

  prc2d_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .valid_in  (stage_vld[CORDIC_STAGES]),
    .st_in     (stage_st[CORDIC_STAGES]),
    .obs_dx    (obs_dx_r),
    .obs_dy    (obs_dy_r),
    .tw        (tw_r),
    .rw        (rw_r),
    .valid_r   (out_ch.valid),
    .res_x_r   (out_ch.residual_x),
    .res_y_r   (out_ch.residual_y),
    .res_ang_r (out_ch.residual_angle),
    .wc_out_r  (out_ch.weighted_cosine),
    .ws_out_r  (out_ch.weighted_sine),
    .jx_r      (out_ch.jac_x_by_heading),
    .jy_r      (out_ch.jac_y_by_heading)
  );

  // An accepted transaction always lands in the front stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> stage_vld[0])
    else $error("accepted transaction missing from front stage");

  // An empty output register never holds off the input.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output register");

  // A stall keeps items in flight.
  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    stage_vld[CORDIC_STAGES] && !adv |=> stage_vld[CORDIC_STAGES])
    else $error("item lost during stall");

endmodule
